/* hdl/static_linked_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the static linked list engine
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STATIC_LINKED_LIST_ENGINE_DEFINES_SVH
`define STATIC_LINKED_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define SLLE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/slle_pkg.sv */
// ----------------------------------------------------------------------------
// slle_pkg
// Types, constants and link helpers shared by the linked list engine.
// ----------------------------------------------------------------------------
package slle_pkg;

  localparam int SLOTS  = 32;
  localparam int LINK_W = $clog2(SLOTS);
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  // wide enough for a position and for SLOTS itself
  localparam int CNT_W  = (LINK_W + 1 > POS_W) ? LINK_W + 1 : POS_W;

  typedef logic [LINK_W-1:0] link_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LIST   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_INS_WR,
    ST_DEL_CHK,
    ST_DEL_STEP,
    ST_DEL_FIN,
    ST_DEL_FREE,
    ST_LST_RD,
    ST_LST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [VAL_W-1:0] data_out;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic  we;
    link_t waddr;
    link_t wdata;
    logic  re;
    link_t raddr;
  } link_req_t;

  // A link at or above SLOTS counts as null.
  function automatic link_t norm_link(link_t x);
    return ({1'b0, x} < (LINK_W+1)'(SLOTS)) ? x : '0;
  endfunction

  // Link value of an entry after reset: free chain 2 .. SLOTS-1, then null.
  function automatic link_t reset_link(link_t a);
    link_t r;
    r = '0;
    if ({1'b0, a} >= (LINK_W+1)'(2) && {1'b0, a} < (LINK_W+1)'(SLOTS - 1)) begin
      r = LINK_W'({1'b0, a} + 1'b1);
    end
    return r;
  endfunction

endpackage

/* hdl/static_linked_list_engine.sv */
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Insert links the free head slot in as the new data head. Delete at
// position k walks to that element, unlinks it and frees its slot. List:
// up to SLOTS-2 elements, via the one read port of the link and value RAMs.
// One item at a time; in_stall_o is high until the item's last transfer is
// loaded. Reset is immediate: link valid bits clear, no clearing pass.
// ----------------------------------------------------------------------------
`include "static_linked_list_engine_defines.svh"

module static_linked_list_engine import slle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  state_e             state_q, state_d;
  link_t              data_head_q, data_head_d;
  link_t              free_head_q, free_head_d;
  link_t              cur_q, cur_d;
  link_t              prev_q, prev_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [VAL_W-1:0]   val_q, val_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  status_e            resp_q, resp_d;

  logic               out_valid_q;
  out_item_t          out_q;
  logic               out_free;
  logic               emit;
  out_item_t          emit_item;

  link_req_t          link_req;
  link_t              link_rd;
  link_t              link_nxt;
  logic               val_we;
  logic               val_re;
  link_t              val_raddr;
  logic [VAL_W-1:0]   val_rd;
  logic               in_xfer;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign link_nxt = norm_link(link_rd);

  slle_link_store u_links (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rd)
  );

  slle_ram #(
    .WIDTH (VAL_W),
    .DEPTH (SLOTS)
  ) u_values (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (cur_q),
    .wdata_i (val_q),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      data_head_q <= '0;
      free_head_q <= LINK_W'(2);
    end else begin
      state_q     <= state_d;
      data_head_q <= data_head_d;
      free_head_q <= free_head_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    cnt_q  <= cnt_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    resp_q <= resp_d;
  end

  always_comb begin
    state_d     = state_q;
    data_head_d = data_head_q;
    free_head_d = free_head_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    pos_d       = pos_q;
    resp_d      = resp_q;
    link_req    = '0;
    val_we      = 1'b0;
    val_re      = 1'b0;
    val_raddr   = cur_q;
    emit        = 1'b0;
    emit_item   = '{status: STATUS_OK, data_out: '0, last: 1'b1};

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          val_d = in_data_i.value;
          pos_d = in_data_i.position;
          case (in_data_i.op)
            OP_INSERT: begin
              cur_d = norm_link(free_head_q);
              if (norm_link(free_head_q) == '0) begin
                resp_d  = STATUS_FULL;
                state_d = ST_RESP;
              end else begin
                link_req.re    = 1'b1;
                link_req.raddr = norm_link(free_head_q);
                state_d        = ST_INS_WR;
              end
            end
            OP_DELETE: begin
              cur_d  = norm_link(data_head_q);
              prev_d = '0;
              cnt_d  = CNT_W'(1);
              if (in_data_i.position == '0) begin
                resp_d  = STATUS_BADPOS;
                state_d = ST_RESP;
              end else begin
                state_d = ST_DEL_CHK;
              end
            end
            OP_LIST: begin
              cur_d = norm_link(data_head_q);
              cnt_d = '0;
              if (norm_link(data_head_q) == '0) begin
                resp_d  = STATUS_EMPTY;
                state_d = ST_RESP;
              end else begin
                state_d = ST_LST_RD;
              end
            end
            default: begin
              // unused code: drop without a result
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_RESP: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_item.status = resp_q;
          state_d          = ST_IDLE;
        end
      end

      ST_INS_WR: begin
        if (out_free) begin
          free_head_d    = link_nxt;
          link_req.we    = 1'b1;
          link_req.waddr = cur_q;
          link_req.wdata = norm_link(data_head_q);
          val_we         = 1'b1;
          data_head_d    = cur_q;
          emit           = 1'b1;
          state_d        = ST_IDLE;
        end
      end

      ST_DEL_CHK: begin
        if (cur_q == '0) begin
          resp_d  = STATUS_BADPOS;
          state_d = ST_RESP;
        end else if (cnt_q == CNT_W'(pos_q)) begin
          link_req.re    = 1'b1;
          link_req.raddr = cur_q;
          val_re         = 1'b1;
          state_d        = ST_DEL_FIN;
        end else if (cnt_q < CNT_W'(SLOTS)) begin
          link_req.re    = 1'b1;
          link_req.raddr = cur_q;
          state_d        = ST_DEL_STEP;
        end else begin
          resp_d  = STATUS_BADPOS;
          state_d = ST_RESP;
        end
      end

      ST_DEL_STEP: begin
        prev_d  = cur_q;
        cur_d   = link_nxt;
        cnt_d   = cnt_q + 1'b1;
        state_d = ST_DEL_CHK;
      end

      ST_DEL_FIN: begin
        // unlink from predecessor or head
        if (prev_q == '0) begin
          data_head_d = link_nxt;
        end else begin
          link_req.we    = 1'b1;
          link_req.waddr = prev_q;
          link_req.wdata = link_nxt;
        end
        state_d = ST_DEL_FREE;
      end

      ST_DEL_FREE: begin
        if (out_free) begin
          link_req.we        = 1'b1;
          link_req.waddr     = cur_q;
          link_req.wdata     = norm_link(free_head_q);
          free_head_d        = cur_q;
          emit               = 1'b1;
          emit_item.data_out = val_rd;
          state_d            = ST_IDLE;
        end
      end

      ST_LST_RD: begin
        link_req.re    = 1'b1;
        link_req.raddr = cur_q;
        val_re         = 1'b1;
        state_d        = ST_LST_EMIT;
      end

      ST_LST_EMIT: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_item.data_out = val_rd;
          emit_item.last     = (link_nxt == '0) || (cnt_q >= CNT_W'(SLOTS - 3));
          if (emit_item.last) begin
            state_d = ST_IDLE;
          end else begin
            cur_d   = link_nxt;
            cnt_d   = cnt_q + 1'b1;
            state_d = ST_LST_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_item;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SLLE_ASSERT_IMPL(a_heads_disjoint, data_head_q != '0,
    data_head_q != free_head_q, "data and free lists share a head slot")
  `SLLE_ASSERT_IMPL(a_emit_state, emit,
    state_q == ST_RESP || state_q == ST_INS_WR || state_q == ST_DEL_FREE ||
    state_q == ST_LST_EMIT, "result loaded outside an emitting state")
  `SLLE_ASSERT_NEXT(a_insert_busy, in_xfer && in_data_i.op == OP_INSERT,
    state_q != ST_IDLE, "insert transfer produced no work")
  `SLLE_ASSERT_IMPL(a_list_bound, state_q == ST_LST_EMIT,
    cnt_q < CNT_W'(SLOTS - 2), "list walk ran past the slot count")

endmodule

/* hdl/slle_ram.sv */
// ----------------------------------------------------------------------------
// slle_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module slle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/slle_link_store.sv */
// ----------------------------------------------------------------------------
// slle_link_store
// Link store: RAM plus one valid bit per slot; unwritten slots read as
// their reset link, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module slle_link_store import slle_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  link_req_t req_i,
  output link_t     rdata_o
);

  logic [SLOTS-1:0] vld_q;
  logic             rd_vld_q;
  link_t            rd_addr_q;
  link_t            ram_rdata;

  slle_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr),
    .wdata_i (req_i.wdata),
    .re_i    (req_i.re),
    .raddr_i (req_i.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  // sample validity alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_vld_q  <= vld_q[req_i.raddr];
      rd_addr_q <= req_i.raddr;
    end
  end

  assign rdata_o = rd_vld_q ? ram_rdata : reset_link(rd_addr_q);

endmodule
